>>> hw/rtl/wto_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, reset values and status types for the wavetable oscillator.
package wto_pkg;

	localparam int CMD_W      = 2;
	localparam int TIDX_W     = 12;
	localparam int TVAL_W     = 16;
	localparam int AMP_W      = 16;
	localparam int FREQ_W     = 24;
	localparam int ACC_W      = 24;
	localparam int SAMPLE_W   = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int TSIZE_W = 13;
	localparam int SCALE_W = 32;
	localparam int TURNS_W = 24;

	localparam logic [TSIZE_W-1:0] TSIZE_RST = 13'd4096;
	localparam logic [SCALE_W-1:0] SCALE_RST = 32'd366503875;
	localparam logic [TURNS_W-1:0] TURNS_RST = 24'd0;

	localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 25'sd8388607;
	localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -25'sd8388608;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_GEN     = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TABLE_SIZE  = 2'd0,
		REG_PHASE_SCALE = 2'd1,
		REG_START_PHASE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} red_stat_t;

endpackage

>>> hw/rtl/wto_if.sv
`timescale 1ns / 1ps
// Stream and configuration channel interfaces of the wavetable oscillator.
interface wto_item_if;
	import wto_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [TIDX_W-1:0]        table_index;
	logic signed [TVAL_W-1:0] table_value;
	logic signed [AMP_W-1:0]  amp;
	logic signed [FREQ_W-1:0] freq;
	logic signed [ACC_W-1:0]  acc_in;
	modport source (output valid, cmd, table_index, table_value, amp, freq, acc_in,
		input ready);
	modport sink (input valid, cmd, table_index, table_value, amp, freq, acc_in,
		output ready);
endinterface

interface wto_result_if;
	import wto_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       saturated;
	modport source (output valid, sample, saturated, input ready);
	modport sink (input valid, sample, saturated, output ready);
endinterface

interface wto_cfg_if;
	import wto_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wavetable_oscillator_accumulate.sv
`timescale 1ns / 1ps
// Top level of the truncating wavetable oscillator that adds into a sample stream.
//
// Wavetable oscillator, one word per cycle unless stalled. A load word (cmd 0)
// writes one Q1.15 entry into the wave table, a single-port synchronous memory
// of TABLE_DEPTH words; a generate word (cmd 1) reads the table at the integer
// part of the phase, scales the entry by amp, adds it into acc_in with
// saturation and returns one result word; a restart word (cmd 2) sets the
// phase to start_phase_turns times the active table size; cmd 3 is dropped.
// The block sustains one word per cycle in both directions while the output is
// taken and no phase reduction runs. A result passes through the stage registers
// s1 to s5 after its word is accepted, s5 being the output register: s1 forms
// |freq|*phase_scale, s2 clamps the increment, s3 reads or writes the table and
// advances the phase, s4 multiplies the entry by amp, s5 adds and saturates. The
// phase register is read and written only in s3, so one generate word per cycle
// keeps the loop full without forwarding. After table_size is lowered below the
// stored phase, the next generate word holds s3 while a shift-subtract unit
// reduces the phase; at all other times the rate is set by the handshakes alone.
// The table needs no clearing after reset: reading an entry never loaded gives
// an undefined sample. Configuration writes are taken every cycle and must be made
// while the block holds no word; the derived values are registered from them.
module wavetable_oscillator_accumulate #(
	parameter int TABLE_DEPTH     = 4096,
	parameter int PHASE_FRAC_BITS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	wto_item_if.sink     item,
	wto_result_if.source result,
	wto_cfg_if.sink      cfg
);
	import wto_pkg::*;

	localparam int IW        = $clog2(TABLE_DEPTH);
	localparam int SW        = $clog2(TABLE_DEPTH + 1);
	localparam int PW        = IW + PHASE_FRAC_BITS;
	localparam int MW        = PW + 1;
	localparam int PRW       = FREQ_W + SCALE_W;
	localparam int TPW       = TURNS_W + SW;
	localparam int RSW       = TPW + 8;
	localparam int INC_SHIFT = 40 - PHASE_FRAC_BITS;
	localparam int RST_SHIFT = 32 - PHASE_FRAC_BITS;
	localparam int SIZE_RST  = (TABLE_DEPTH < 4096) ? TABLE_DEPTH : 4096;

	// ---------------------------------------------------------------------
	// Configuration registers and values derived from them
	// ---------------------------------------------------------------------
	logic [TSIZE_W-1:0] tsize_q;
	logic [SCALE_W-1:0] scale_q;
	logic [TURNS_W-1:0] turns_q;
	logic [SW-1:0]      size_q;
	logic [MW-1:0]      mod_q;
	logic [PW-1:0]      restart_q;
	logic [SW-1:0]      size_nx;
	logic [TPW-1:0]     turns_prod;
	logic [RSW-1:0]     restart_nx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TSIZE_RST;
			scale_q <= SCALE_RST;
			turns_q <= TURNS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TABLE_SIZE:  tsize_q <= cfg.data[TSIZE_W-1:0];
				REG_PHASE_SCALE: scale_q <= cfg.data[SCALE_W-1:0];
				REG_START_PHASE: turns_q <= cfg.data[TURNS_W-1:0];
				default: ;
			endcase
		end
	end

	// Size zero acts as one entry, sizes past the memory act as the full memory.
	always_comb begin
		if (tsize_q == '0) begin
			size_nx = SW'(1);
		end else if (32'(tsize_q) > 32'(TABLE_DEPTH)) begin
			size_nx = SW'(TABLE_DEPTH);
		end else begin
			size_nx = SW'(tsize_q);
		end
		turns_prod = TPW'(turns_q) * TPW'(size_q);
		restart_nx = (RSW'(turns_prod) << 8) >> RST_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SW'(SIZE_RST);
			mod_q     <= MW'(SIZE_RST) << PHASE_FRAC_BITS;
			restart_q <= '0;
		end else begin
			size_q    <= size_nx;
			mod_q     <= MW'(size_nx) << PHASE_FRAC_BITS;
			restart_q <= restart_nx[PW-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Flow control: each stage moves when the one behind it frees up
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, ov_q;
	logic f1, f2, f3, f4, rdy_out;
	logic gen2, need_reduce, go2;
	red_stat_t red_stat;

	assign rdy_out = !ov_q || result.ready;
	assign f4      = !v_s4 || rdy_out;
	assign f3      = !v_s3 || f4;
	assign f2      = !v_s2 || go2;
	assign f1      = !v_s1 || f2;
	assign item.ready = f1;

	// ---------------------------------------------------------------------
	// s1: magnitude of freq times phase_scale
	// ---------------------------------------------------------------------
	logic [CMD_W-1:0]         cmd_s1;
	logic [TIDX_W-1:0]        tidx_s1;
	logic [TVAL_W-1:0]        tval_s1;
	logic signed [AMP_W-1:0]  amp_s1;
	logic signed [ACC_W-1:0]  acc_s1;
	logic                     neg_s1;
	logic [PRW-1:0]           prod_s1;
	logic [FREQ_W-1:0]        mag;

	assign mag = item.freq[FREQ_W-1] ? FREQ_W'(-item.freq) : FREQ_W'(item.freq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (f1) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (f1 && item.valid) begin
			cmd_s1  <= item.cmd;
			tidx_s1 <= item.table_index;
			tval_s1 <= item.table_value;
			amp_s1  <= item.amp;
			acc_s1  <= item.acc_in;
			neg_s1  <= item.freq[FREQ_W-1];
			prod_s1 <= PRW'(mag) * PRW'(scale_q);
		end
	end

	// ---------------------------------------------------------------------
	// s2: drop the extra fraction bits and clamp one step below the modulus
	// ---------------------------------------------------------------------
	logic [CMD_W-1:0]        cmd_s2;
	logic [TIDX_W-1:0]       tidx_s2;
	logic [TVAL_W-1:0]       tval_s2;
	logic signed [AMP_W-1:0] amp_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic                    neg_s2;
	logic [PW-1:0]           inc_s2;
	logic [PRW-1:0]          inc_raw;
	logic [PRW-1:0]          inc_lim;

	assign inc_raw = prod_s1 >> INC_SHIFT;
	assign inc_lim = PRW'(mod_q - MW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (f2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && f2) begin
			cmd_s2  <= cmd_s1;
			tidx_s2 <= tidx_s1;
			tval_s2 <= tval_s1;
			amp_s2  <= amp_s1;
			acc_s2  <= acc_s1;
			neg_s2  <= neg_s1;
			inc_s2  <= (inc_raw > inc_lim) ? inc_lim[PW-1:0] : inc_raw[PW-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// s3 (stage register _s2 in flight): table access and phase update
	// ---------------------------------------------------------------------
	logic [PW-1:0] phase_q;
	logic [MW-1:0] ph_ext, inc_ext, ph_sum, ph_dif, phase_nx;
	logic          load_ok, we, re;
	logic          red_start;
	logic [IW-1:0] red_rem;

	assign gen2        = v_s2 && (cmd_s2 == CMD_GEN);
	// A phase past a shrunk table must be reduced before the read.
	assign need_reduce = gen2 && ({1'b0, phase_q} >= mod_q);
	assign go2         = v_s2 && !red_stat.busy && !need_reduce && (!gen2 || f3);
	assign red_start   = need_reduce && !red_stat.busy;
	assign load_ok     = 32'(tidx_s2) < 32'(TABLE_DEPTH);
	assign we          = go2 && (cmd_s2 == CMD_LOAD) && load_ok;
	assign re          = go2 && gen2;

	wto_phase_mod #(
		.IW (IW),
		.SW (SW)
	) u_phase_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (red_start),
		.dividend  (phase_q[PW-1:PHASE_FRAC_BITS]),
		.divisor   (size_q),
		.stat      (red_stat),
		.remainder (red_rem)
	);

	// Advance forward with one wrap subtract; step back with one wrap add.
	always_comb begin
		ph_ext  = {1'b0, phase_q};
		inc_ext = {1'b0, inc_s2};
		ph_sum  = ph_ext + inc_ext;
		ph_dif  = ph_ext - inc_ext;
		if (!neg_s2) begin
			phase_nx = (ph_sum >= mod_q) ? (ph_sum - mod_q) : ph_sum;
		end else begin
			phase_nx = (inc_ext > ph_ext) ? (ph_dif + mod_q) : ph_dif;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (red_stat.done) begin
			phase_q <= {red_rem, phase_q[PHASE_FRAC_BITS-1:0]};
		end else if (go2 && gen2) begin
			phase_q <= phase_nx[PW-1:0];
		end else if (go2 && (cmd_s2 == CMD_RESTART)) begin
			phase_q <= restart_q;
		end
	end

	logic [TVAL_W-1:0]        wave_mem [TABLE_DEPTH];
	logic signed [TVAL_W-1:0] rdata_s3;

	always_ff @(posedge clk) begin
		if (we) begin
			wave_mem[tidx_s2[IW-1:0]] <= tval_s2;
		end
		if (re) begin
			rdata_s3 <= wave_mem[phase_q[PW-1:PHASE_FRAC_BITS]];
		end
	end

	logic signed [AMP_W-1:0] amp_s3;
	logic signed [ACC_W-1:0] acc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (f3) begin
			v_s3 <= go2 && gen2;
		end
	end

	always_ff @(posedge clk) begin
		if (go2 && gen2) begin
			amp_s3 <= amp_s2;
			acc_s3 <= acc_s2;
		end
	end

	// ---------------------------------------------------------------------
	// s4: amp times table word, Q2.30
	// ---------------------------------------------------------------------
	logic signed [2*AMP_W-1:0] prod_s4;
	logic signed [ACC_W-1:0]   acc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (f4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && f4) begin
			prod_s4 <= amp_s3 * rdata_s3;
			acc_s4  <= acc_s3;
		end
	end

	// ---------------------------------------------------------------------
	// s5: floor the product to Q9.15, add and saturate into the output word
	// ---------------------------------------------------------------------
	logic signed [SAMPLE_W:0]   sum;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       sat_q;

	assign sum = (SAMPLE_W + 1)'(acc_s4) + (SAMPLE_W + 1)'(prod_s4 >>> 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (v_s4 && rdy_out) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy_out) begin
			if (sum > SAMPLE_MAX) begin
				sample_q <= SAMPLE_MAX[SAMPLE_W-1:0];
				sat_q    <= 1'b1;
			end else if (sum < SAMPLE_MIN) begin
				sample_q <= SAMPLE_MIN[SAMPLE_W-1:0];
				sat_q    <= 1'b1;
			end else begin
				sample_q <= sum[SAMPLE_W-1:0];
				sat_q    <= 1'b0;
			end
		end
	end

	assign result.valid     = ov_q;
	assign result.sample    = sample_q;
	assign result.saturated = sat_q;

`ifndef SYNTHESIS
	// The remainder unit only runs under a generate word parked in the table stage.
	a_reduce_under_gen: assert property (@(posedge clk) disable iff (!arst_n)
		red_stat.busy |-> gen2)
		else $error("phase reduction running without a generate word in the table stage");

	// A stalled table stage must not move the phase.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !go2 && !red_stat.busy) |=> $stable(phase_q))
		else $error("phase moved while the table stage was stalled");

	// A new output word comes only from a filled add stage.
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(v_s4))
		else $error("output word appeared without a word in the add stage");
`endif

endmodule

>>> hw/rtl/wto_phase_mod.sv
`timescale 1ns / 1ps
// Iterative remainder unit: integer phase modulo table size, one quotient bit per cycle.
module wto_phase_mod #(
	parameter int IW = 12,
	parameter int SW = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IW-1:0]       dividend,
	input  logic [SW-1:0]       divisor,
	output wto_pkg::red_stat_t  stat,
	output logic [IW-1:0]       remainder
);
	import wto_pkg::*;

	localparam int KW = $clog2(IW);
	localparam int EW = IW + SW;

	logic [IW-1:0] rem_q;
	logic [SW-1:0] div_q;
	logic [KW-1:0] k_q;
	logic          busy_q;
	logic [EW-1:0] shifted;
	logic          fits;
	logic [IW-1:0] rem_nx;

	// Try to take divisor << k off the partial remainder.
	always_comb begin
		shifted = EW'(div_q) << k_q;
		fits    = {{SW{1'b0}}, rem_q} >= shifted;
		rem_nx  = fits ? (rem_q - shifted[IW-1:0]) : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= KW'(IW - 1);
		end else if (busy_q) begin
			if (k_q == KW'(0)) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q - KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (k_q == KW'(0));
	assign remainder = rem_nx;

endmodule
